>>> rtl/core/sblur_pkg.sv
// Shared types, commands and scale tables for the stack blur line filter.
package sblur_pkg;

    localparam int RadW = 6;   // radius register width
    localparam int WgtW = 7;   // tap weight width (up to 64)
    localparam int PixW = 32;  // four 8-bit channels
    localparam int AccW = 21;  // weighted sum per channel
    localparam int MulW = 10;  // scale multiplier width
    localparam int PrdW = AccW + MulW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_MUL,
        ST_SCALE,
        ST_WAIT
    } t_state;

    // Controller to datapath command group
    typedef struct packed {
        logic            wr_en;
        logic            rd_en;
        logic            rd_first;
        logic [WgtW-1:0] weight;
        logic            mul_en;
        logic            out_load;
        logic            pass_load;
        logic [RadW-1:0] radius;
    } t_cmd;

    localparam logic [MulW-1:0] MUL_ROM [64] = '{
        10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
        10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
        10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
        10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
        10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
        10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
        10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
        10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
    };

    localparam logic [4:0] SHR_ROM [64] = '{
        5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15,
        5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd17, 5'd17, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
        5'd18, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd21
    };

endpackage

>>> rtl/core/sblur_datapath.sv
// Datapath: pixel ring memory, tap accumulators, scaling and output register.
module sblur_datapath #(
    parameter int Depth = 127,
    parameter int AddrW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sblur_pkg::t_cmd           i_cmd,
    input  logic [AddrW-1:0]          i_wr_addr,
    input  logic [AddrW-1:0]          i_rd_addr,
    input  logic [sblur_pkg::PixW-1:0] i_pixel,
    output logic [sblur_pkg::PixW-1:0] o_pixel
);
    import sblur_pkg::*;

    logic [PixW-1:0] r_ring [Depth];
    logic [PixW-1:0] r_rd_data;
    logic            r_rd_v;
    logic            r_rd_first;
    logic [WgtW-1:0] r_rd_w;
    logic [AccW-1:0] r_acc [4];
    logic [PrdW-1:0] r_prd [4];
    logic [PixW-1:0] r_out;
    logic [PrdW-1:0] shifted [4];

    // Write new pixels, read one tap per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_ring[i_wr_addr] <= i_pixel;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_ring[i_rd_addr];
        end
        r_rd_first <= i_cmd.rd_first;
        r_rd_w     <= i_cmd.weight;
    end

    // Track read data valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
        end
    end

    // Accumulate, scale and load the output
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (r_rd_v) begin
                r_acc[c] <= (r_rd_first ? AccW'(0) : r_acc[c])
                    + AccW'(r_rd_data[8*c +: 8]) * AccW'(r_rd_w);
            end
            if (i_cmd.mul_en) begin
                r_prd[c] <= PrdW'(r_acc[c]) * PrdW'(MUL_ROM[i_cmd.radius]);
            end
        end
        if (i_cmd.pass_load) begin
            r_out <= i_pixel;
        end else if (i_cmd.out_load) begin
            for (int c = 0; c < 4; c++) begin
                r_out[8*c +: 8] <= (shifted[c] > PrdW'(255)) ? 8'hff : shifted[c][7:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            shifted[c] = r_prd[c] >> SHR_ROM[i_cmd.radius];
        end
    end

    assign o_pixel = r_out;

endmodule

>>> rtl/core/sblur_controller.sv
// Controller: line tracking, tap sequencing and handshakes.
module sblur_controller #(
    parameter int MaxRadius = 63,
    parameter int Depth     = 127,
    parameter int AddrW     = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_last,
    output logic                      o_stall,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_line_end,
    input  logic                      i_cfg_valid,
    input  logic [sblur_pkg::RadW-1:0] i_cfg_data,
    output logic                      o_cfg_ready,
    output sblur_pkg::t_cmd           o_cmd,
    output logic [AddrW-1:0]          o_wr_addr,
    output logic [AddrW-1:0]          o_rd_addr,
    output logic [sblur_pkg::RadW-1:0] o_radius_cfg
);
    import sblur_pkg::*;

    localparam int PosTop = 2 * MaxRadius + 1;
    localparam int PosW   = $clog2(PosTop + 1);
    localparam int KW     = $clog2(MaxRadius + 1) + 1;
    localparam int DW     = KW + 2;

    t_state                 r_state, n_state;
    logic [RadW-1:0]        r_cfg, r_rad, n_rad;
    logic [PosW-1:0]        r_pos, n_pos, r_n, n_n;
    logic [AddrW-1:0]       r_ptr, n_ptr, r_newest, n_newest;
    logic [RadW-1:0]        r_j, n_j;
    logic signed [KW-1:0]   r_k, n_k;
    logic                   r_more, n_more;
    logic                   r_valid, n_valid;
    logic                   r_end, n_end;
    logic                   accept;
    logic [RadW-1:0]        rad_now;
    logic [PosW-1:0]        pos_inc;
    logic [AddrW-1:0]       ptr_inc;
    logic signed [DW-1:0]   d_raw;
    logic [DW-1:0]          d_cl;
    logic [AddrW:0]         addr_tmp;
    logic [RadW-1:0]        abs_k;

    assign accept      = (r_state == ST_IDLE) && i_valid;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_line_end  = r_end;
    assign o_wr_addr   = r_ptr;
    assign o_radius_cfg = r_cfg;

    assign rad_now = (r_pos == '0) ? r_cfg : r_rad;
    assign pos_inc = (r_pos == PosW'(PosTop)) ? r_pos : r_pos + 1'b1;
    assign ptr_inc = (r_ptr == AddrW'(Depth - 1)) ? '0 : r_ptr + 1'b1;

    // Tap address: clamp the offset into the line, then step back from newest
    always_comb begin
        d_raw = DW'($signed({1'b0, r_j})) - DW'(r_k);
        if (d_raw < 0) begin
            d_cl = '0;
        end else if (d_raw > DW'($signed({1'b0, r_n}))) begin
            d_cl = DW'(r_n);
        end else begin
            d_cl = d_raw;
        end
        addr_tmp = {1'b0, r_newest} - (AddrW + 1)'(d_cl);
        if ((AddrW + 1)'(r_newest) < (AddrW + 1)'(d_cl)) begin
            addr_tmp = addr_tmp + (AddrW + 1)'(Depth);
        end
        abs_k = (r_k < 0) ? RadW'(-r_k) : RadW'(r_k);
    end
    assign o_rd_addr = addr_tmp[AddrW-1:0];

    // Hold state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= '0;
            r_rad   <= '0;
            r_pos   <= '0;
            r_n     <= '0;
            r_ptr   <= '0;
            r_newest <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_more  <= 1'b0;
            r_valid <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= (i_cfg_data > RadW'(MaxRadius)) ? RadW'(MaxRadius) : i_cfg_data;
            end
            r_rad   <= n_rad;
            r_pos   <= n_pos;
            r_n     <= n_n;
            r_ptr   <= n_ptr;
            r_newest <= n_newest;
            r_j     <= n_j;
            r_k     <= n_k;
            r_more  <= n_more;
            r_valid <= n_valid;
            r_end   <= n_end;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_rad    = r_rad;
        n_pos    = r_pos;
        n_n      = r_n;
        n_ptr    = r_ptr;
        n_newest = r_newest;
        n_j      = r_j;
        n_k      = r_k;
        n_more   = r_more;
        n_valid  = r_valid;
        n_end    = r_end;
        o_cmd    = '0;
        o_cmd.radius = r_rad;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rad = rad_now;
                    if (rad_now <= RadW'(1)) begin
                        // pass the pixel straight through
                        o_cmd.pass_load = 1'b1;
                        n_valid = 1'b1;
                        n_end   = i_last;
                        n_more  = 1'b0;
                        n_pos   = i_last ? '0 : pos_inc;
                        n_state = ST_WAIT;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                        n_newest = r_ptr;
                        n_n      = r_pos;
                        n_k      = -KW'(signed'({1'b0, rad_now}));
                        n_more   = i_last;
                        if (i_last) begin
                            n_j   = (PosW'(rad_now) > r_pos) ? RadW'(r_pos) : rad_now;
                            n_pos = '0;
                            n_ptr = '0;
                            n_state = ST_ACC;
                        end else begin
                            n_j   = rad_now;
                            n_pos = pos_inc;
                            n_ptr = ptr_inc;
                            if (r_pos >= PosW'(rad_now)) begin
                                n_state = ST_ACC;
                            end
                        end
                    end
                end
            end
            ST_ACC: begin
                // issue one tap read per cycle
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_k == -KW'(signed'({1'b0, r_rad})));
                o_cmd.weight   = WgtW'(r_rad) + 1'b1 - WgtW'(abs_k);
                n_k = r_k + 1'b1;
                if (r_k == KW'(signed'({1'b0, r_rad}))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.out_load = 1'b1;
                n_valid = 1'b1;
                n_end   = r_more && (r_j == '0);
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                // hold the result until the receiver takes it
                if (!i_stall) begin
                    n_valid = 1'b0;
                    if (r_more && (r_j != '0)) begin
                        n_j = r_j - 1'b1;
                        n_k = -KW'(signed'({1'b0, r_rad}));
                        n_state = ST_ACC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/stack_blur_line_filter_unit.sv
// Top level of the stack blur line filter.
// Usage:
//   Input channel (i_valid / o_stall) carries one BGRA pixel per request with
//   a line-end mark. Output channel (o_valid / i_stall) returns blurred pixels.
//   The radius register is written through i_cfg_valid / o_cfg_ready; it is
//   latched at the first pixel of each line and capped at MAX_RADIUS.
//   One pixel is worked on at a time; o_stall stays high until every result
//   it causes is taken. Radius 0 or 1: the pixel is registered and returned
//   in the cycle after acceptance. Otherwise each result walks the 2r+1 taps
//   through the single read port of the pixel ring, one tap per cycle, then
//   a drain, multiply and scale step, and waits on the output until taken.
//   A pixel that completes no window is absorbed without raising o_stall. A line
//   end emits the remaining up to r+1 results back to back in the same way.
//   Reset clears the line position, ring pointer and radius to zero; the
//   ring contents need no clearing. While the receiver stalls, the result
//   holds on the output and no new pixel is taken.
module stack_blur_line_filter_unit #(
    parameter int MAX_RADIUS = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_blue,
    input  logic [7:0] i_in_green,
    input  logic [7:0] i_in_red,
    input  logic [7:0] i_in_alpha,
    input  logic       i_in_line_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_alpha,
    output logic       o_out_line_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);
    import sblur_pkg::*;

    localparam int Depth = 2 * MAX_RADIUS + 1;
    localparam int AddrW = $clog2(Depth);

    t_cmd             cmd;
    logic [AddrW-1:0] wr_addr, rd_addr;
    logic [PixW-1:0]  pix_out;
    logic [RadW-1:0]  radius_cfg;

    sblur_controller #(
        .MaxRadius (MAX_RADIUS),
        .Depth     (Depth),
        .AddrW     (AddrW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last       (i_in_line_end),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_line_end   (o_out_line_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_cmd        (cmd),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_radius_cfg (radius_cfg)
    );

    sblur_datapath #(
        .Depth (Depth),
        .AddrW (AddrW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_pixel   ({i_in_alpha, i_in_red, i_in_green, i_in_blue}),
        .o_pixel   (pix_out)
    );

    assign o_out_blue  = pix_out[7:0];
    assign o_out_green = pix_out[15:8];
    assign o_out_red   = pix_out[23:16];
    assign o_out_alpha = pix_out[31:24];

`ifndef ASSERT_OFF
    // No new pixel is taken while a result waits
    a_stall_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a result is pending");

    // Latched radius never exceeds the cap
    a_radius_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        radius_cfg <= RadW'(MAX_RADIUS))
        else $error("radius register above cap");

    // A ring write only happens on an accepted pixel
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> (i_valid && !o_stall))
        else $error("ring write without accepted pixel");
`endif

endmodule
